[rtl/srms_pkg.sv]
// srms_pkg: record layout, key width and key function for the stable record merge sort
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package srms_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned KEY_W   = FIELD_W + 1;

  // one stored record, 48 bits
  typedef struct packed {
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] weight;
    logic [FIELD_W-1:0] height;
  } rec_t;

  // sort key: height + weight, which read with 1 fraction bit is the average
  function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
    rec_key = {1'b0, r.height} + {1'b0, r.weight};
  endfunction

endpackage

`default_nettype wire

[rtl/srms_in_if.sv]
// srms_in_if: input channel of the record merge sort, one record per beat
// uses srms_pkg for field widths
`default_nettype none

interface srms_in_if;
  logic                          valid;
  logic                          ready;
  logic [srms_pkg::FIELD_W-1:0]  height_value;
  logic [srms_pkg::FIELD_W-1:0]  weight_value;
  logic [srms_pkg::FIELD_W-1:0]  record_tag;
  logic                          final_record;

  modport source (
    output valid, height_value, weight_value, record_tag, final_record,
    input  ready
  );

  modport sink (
    input  valid, height_value, weight_value, record_tag, final_record,
    output ready
  );
endinterface

`default_nettype wire

[rtl/srms_out_if.sv]
// srms_out_if: output channel of the record merge sort, one sorted record per beat
// uses srms_pkg for field widths
`default_nettype none

interface srms_out_if;
  logic                          valid;
  logic                          ready;
  logic [srms_pkg::FIELD_W-1:0]  sorted_height;
  logic [srms_pkg::FIELD_W-1:0]  sorted_weight;
  logic [srms_pkg::KEY_W-1:0]    record_average;
  logic [srms_pkg::FIELD_W-1:0]  sorted_tag;
  logic                          batch_end;
  logic                          overflow_seen;

  modport source (
    output valid, sorted_height, sorted_weight, record_average, sorted_tag,
           batch_end, overflow_seen,
    input  ready
  );

  modport sink (
    input  valid, sorted_height, sorted_weight, record_average, sorted_tag,
           batch_end, overflow_seen,
    output ready
  );
endinterface

`default_nettype wire

[rtl/stable_record_merge_sort.sv]
// stable_record_merge_sort: loads a batch of records, sorts them by height + weight, emits them
// depends on srms_pkg, srms_in_if and srms_out_if
`default_nettype none

// usage
//   in_i  : one record per beat (height, weight, tag, final mark). ready is high only
//           while the block is loading
//   out_o : after a beat with final_record set, the batch comes out in ascending order
//           of height + weight, equal keys in arrival order; batch_end marks the last
//           beat and overflow_seen is set on every beat of a batch that dropped records
//   records past MAX_RECORDS are dropped; a dropped beat with the final mark still
//   ends the batch
// steps for a batch of n records
//   load: each record taken is written to memory 0 until the store is full
//   sort: ceil(log2 n) merge passes over two ping-pong memories; each record moved
//         takes a registered memory read, then a compare and write, and each run
//         pair starts with a setup step that sets its bounds
//   emit: each beat is a read, then a load of the output register
// the single key compare and the one write port of each memory set the pace of the sort
// a stalled receiver holds the output register and pauses the emit sequencer;
// loading of the next batch starts once the last beat sits in the output register
// reset clears the sequencer, record count, overflow flag and output valid;
// the memories need no clearing since only written entries are read

module stable_record_merge_sort #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  srms_in_if.sink    in_i,
  srms_out_if.source out_o
);

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned SW = CW + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_RECORDS);

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,  // taking records
    S_RUN     = 6'b000010,  // set up bounds of the next run pair
    S_RD      = 6'b000100,  // read heads of both runs
    S_MRG     = 6'b001000,  // compare heads, write winner
    S_EMIT_RD = 6'b010000,  // read next sorted record
    S_EMIT_WR = 6'b100000   // load output register
  } state_e;

  state_e state_q, state_d;

  // batch and merge bookkeeping
  logic [CW-1:0] count_q, count_d;   // records stored so far
  logic          dropped_q, dropped_d;
  logic [CW-1:0] n_q, n_d;           // batch size being sorted
  logic [CW:0]   w_q, w_d;           // current run width
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] i_q, i_d;           // left head, also emit index
  logic [CW-1:0] j_q, j_d;           // right head
  logic [CW-1:0] k_q, k_d;           // destination index
  logic          src_sel_q, src_sel_d;  // memory that holds the current order

  // ping-pong memories, two read ports each, read data registered
  srms_pkg::rec_t mem0_q [MAX_RECORDS];
  srms_pkg::rec_t mem1_q [MAX_RECORDS];
  srms_pkg::rec_t m0_p0_q, m0_p1_q, m1_p0_q, m1_p1_q;

  logic           wr0_en, wr1_en;
  logic [AW-1:0]  wr0_addr;
  srms_pkg::rec_t wr0_data, merge_data;

  // output register
  logic           out_valid_q, out_valid_d;
  srms_pkg::rec_t out_rec_q, out_rec_d;
  logic           out_end_q, out_end_d;
  logic           out_ovf_q, out_ovf_d;

  logic           in_fire, out_free, take_left;
  logic           left_ok, right_ok, run_last;
  srms_pkg::rec_t head_l, head_r, in_rec;
  logic [CW-1:0]  count_inc;
  logic [SW-1:0]  sum_mid, sum_hi;
  logic [CW:0]    w_dbl;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;

  assign in_rec.height = in_i.height_value;
  assign in_rec.weight = in_i.weight_value;
  assign in_rec.tag    = in_i.record_tag;

  assign head_l = src_sel_q ? m1_p0_q : m0_p0_q;
  assign head_r = src_sel_q ? m1_p1_q : m0_p1_q;

  // stable merge: left wins ties
  assign left_ok    = (i_q < mid_q);
  assign right_ok   = (j_q < hi_q);
  assign take_left  = left_ok &
                      (~right_ok | (srms_pkg::rec_key(head_l) <= srms_pkg::rec_key(head_r)));
  assign merge_data = take_left ? head_l : head_r;
  assign run_last   = ((k_q + CW'(1)) == hi_q);

  assign count_inc = count_q + CW'(1);
  assign sum_mid   = SW'(lo_q) + SW'(w_q);
  assign sum_hi    = SW'(lo_q) + SW'({w_q, 1'b0});
  assign w_dbl     = {w_q[CW-1:0], 1'b0};

  // memory 0 takes loads and even-pass merge output, memory 1 odd-pass output
  always_comb begin
    wr0_en   = 1'b0;
    wr0_addr = count_q[AW-1:0];
    wr0_data = in_rec;
    if (state_q == S_LOAD) begin
      wr0_en = in_fire & (count_q < MAX_C);
    end else if (state_q == S_MRG && src_sel_q) begin
      wr0_en   = 1'b1;
      wr0_addr = k_q[AW-1:0];
      wr0_data = merge_data;
    end
  end

  assign wr1_en = (state_q == S_MRG) & ~src_sel_q;

  always_ff @(posedge clk_i) begin
    if (wr0_en) begin
      mem0_q[wr0_addr] <= wr0_data;
    end
    if (wr1_en) begin
      mem1_q[k_q[AW-1:0]] <= merge_data;
    end
    m0_p0_q <= mem0_q[i_q[AW-1:0]];
    m0_p1_q <= mem0_q[j_q[AW-1:0]];
    m1_p0_q <= mem1_q[i_q[AW-1:0]];
    m1_p1_q <= mem1_q[j_q[AW-1:0]];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    n_d         = n_q;
    w_d         = w_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    src_sel_d   = src_sel_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_rec_d   = out_rec_q;
    out_end_d   = out_end_q;
    out_ovf_d   = out_ovf_q;

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (count_q < MAX_C) begin
            count_d = count_inc;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_i.final_record) begin
            n_d       = count_d;
            src_sel_d = 1'b0;
            w_d       = (CW + 1)'(1);
            lo_d      = '0;
            i_d       = '0;
            // a single record needs no merge pass
            state_d   = (count_d <= CW'(1)) ? S_EMIT_RD : S_RUN;
          end
        end
      end
      S_RUN: begin
        mid_d   = (sum_mid < SW'(n_q)) ? sum_mid[CW-1:0] : n_q;
        hi_d    = (sum_hi < SW'(n_q)) ? sum_hi[CW-1:0] : n_q;
        i_d     = lo_q;
        j_d     = mid_d;
        k_d     = lo_q;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_MRG;
      end
      S_MRG: begin
        k_d = k_q + CW'(1);
        if (take_left) begin
          i_d = i_q + CW'(1);
        end else begin
          j_d = j_q + CW'(1);
        end
        if (run_last) begin
          if (hi_q == n_q) begin
            // pass complete: swap memories, double the run width
            src_sel_d = ~src_sel_q;
            w_d       = w_dbl;
            lo_d      = '0;
            if (w_dbl >= (CW + 1)'(n_q)) begin
              i_d     = '0;
              state_d = S_EMIT_RD;
            end else begin
              state_d = S_RUN;
            end
          end else begin
            lo_d    = hi_q;
            state_d = S_RUN;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rec_d   = head_l;
          out_end_d   = ((i_q + CW'(1)) == n_q);
          out_ovf_d   = dropped_q;
          i_d         = i_q + CW'(1);
          if ((i_q + CW'(1)) == n_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            src_sel_d = 1'b0;
            state_d   = S_LOAD;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      src_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      src_sel_q   <= src_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // indices and output payload
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    w_q       <= w_d;
    lo_q      <= lo_d;
    mid_q     <= mid_d;
    hi_q      <= hi_d;
    i_q       <= i_d;
    j_q       <= j_d;
    k_q       <= k_d;
    out_rec_q <= out_rec_d;
    out_end_q <= out_end_d;
    out_ovf_q <= out_ovf_d;
  end

  assign in_i.ready = (state_q == S_LOAD);

  assign out_o.valid          = out_valid_q;
  assign out_o.sorted_height  = out_rec_q.height;
  assign out_o.sorted_weight  = out_rec_q.weight;
  assign out_o.record_average = srms_pkg::rec_key(out_rec_q);
  assign out_o.sorted_tag     = out_rec_q.tag;
  assign out_o.batch_end      = out_end_q;
  assign out_o.overflow_seen  = out_ovf_q;

endmodule

`default_nettype wire

[sim/testbench.sv]
// testbench: drives record batches into stable_record_merge_sort and checks the sorted beats
// depends on srms_pkg, srms_in_if, srms_out_if and the rtl top level
`default_nettype none

module testbench;

  localparam int unsigned MAX_RECORDS  = 64;
  localparam int          RANDOM_ITEMS = 10;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 400000;

  // one sorted beat as the receiver sees it
  typedef struct packed {
    logic [srms_pkg::FIELD_W-1:0] height;
    logic [srms_pkg::FIELD_W-1:0] weight;
    logic [srms_pkg::KEY_W-1:0]   average;
    logic [srms_pkg::FIELD_W-1:0] tag;
    logic                         last;
    logic                         dropped;
  } sorted_beat_t;

  // directed stimulus row; want is only used where typed is set
  typedef struct packed {
    logic [srms_pkg::FIELD_W-1:0] h;
    logic [srms_pkg::FIELD_W-1:0] w;
    logic [srms_pkg::FIELD_W-1:0] tag;
    logic                         fin;
    logic                         typed;
    sorted_beat_t                 want;
  } stim_row_t;

  localparam int DIR_ROWS = 21;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // one-record batches at the field extremes, result read off directly
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{16'h0000, 16'h0000, 17'h00000, 16'h0000, 1'b1, 1'b0}},
    '{16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1,
      '{16'hffff, 16'hffff, 17'h1fffe, 16'hffff, 1'b1, 1'b0}},
    '{16'h0000, 16'hffff, 16'h0001, 1'b1, 1'b1,
      '{16'h0000, 16'hffff, 17'h0ffff, 16'h0001, 1'b1, 1'b0}},
    '{16'hffff, 16'h0000, 16'h0002, 1'b1, 1'b1,
      '{16'hffff, 16'h0000, 17'h0ffff, 16'h0002, 1'b1, 1'b0}},
    // all keys equal: arrival order must survive
    '{16'h0010, 16'h0030, 16'h0010, 1'b0, 1'b0, '0},
    '{16'h0040, 16'h0000, 16'h0011, 1'b0, 1'b0, '0},
    '{16'h0020, 16'h0020, 16'h0012, 1'b0, 1'b0, '0},
    '{16'h0000, 16'h0040, 16'h0013, 1'b1, 1'b0, '0},
    // strictly descending keys
    '{16'h0500, 16'h0500, 16'h0020, 1'b0, 1'b0, '0},
    '{16'h0400, 16'h0400, 16'h0021, 1'b0, 1'b0, '0},
    '{16'h0300, 16'h0300, 16'h0022, 1'b0, 1'b0, '0},
    '{16'h0200, 16'h0200, 16'h0023, 1'b0, 1'b0, '0},
    '{16'h0100, 16'h0100, 16'h0024, 1'b1, 1'b0, '0},
    // mixed extremes with a run of equal keys in the middle
    '{16'hffff, 16'h0001, 16'h0030, 1'b0, 1'b0, '0},
    '{16'h0000, 16'h0000, 16'h0031, 1'b0, 1'b0, '0},
    '{16'h8000, 16'h7fff, 16'h0032, 1'b0, 1'b0, '0},
    '{16'h7fff, 16'h8000, 16'h0033, 1'b0, 1'b0, '0},
    '{16'h0001, 16'h0000, 16'h0034, 1'b0, 1'b0, '0},
    '{16'haaaa, 16'h5555, 16'h0035, 1'b1, 1'b0, '0},
    // alternating bit patterns, equal keys
    '{16'h5555, 16'haaaa, 16'haaaa, 1'b0, 1'b0, '0},
    '{16'haaaa, 16'h5555, 16'h5555, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  srms_in_if  in_ch ();
  srms_out_if out_ch ();

  stable_record_merge_sort #(
    .MAX_RECORDS(MAX_RECORDS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor state: records of the batch being loaded, and whether any were dropped
  srms_pkg::rec_t batch_q[$];
  logic           batch_dropped;
  // sorted beats still to come out, oldest first
  sorted_beat_t   due_sorted_q[$];

  sorted_beat_t head;
  int           fail_count  = 0;
  int           cycle_count = 0;
  int           stall_left  = 0;
  logic         quiet;        // no idling on either side while set
  logic         hold_armed;   // receiver holds off once the next beat shows up

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [srms_pkg::KEY_W-1:0] sum_key(input srms_pkg::rec_t r);
    return srms_pkg::KEY_W'(r.height) + srms_pkg::KEY_W'(r.weight);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one record, wait for its beat, then update the expected sorted output
  task automatic put_record(input srms_pkg::rec_t r, input logic fin, input logic typed,
                            input sorted_beat_t want);
    int             gap;
    int             n;
    int             j;
    srms_pkg::rec_t moving;
    sorted_beat_t   beat;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.height_value = r.height;
    in_ch.weight_value = r.weight;
    in_ch.record_tag   = r.tag;
    in_ch.final_record = fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    // beat taken: store it or note the drop once the store is full
    if (batch_q.size() < MAX_RECORDS) batch_q.push_back(r);
    else batch_dropped = 1'b1;

    if (fin) begin
      n = batch_q.size();
      // stable insertion sort: a record only moves past strictly larger keys
      for (int i = 1; i < n; i++) begin
        moving = batch_q[i];
        j = i;
        while (j > 0 && sum_key(batch_q[j-1]) > sum_key(moving)) begin
          batch_q[j] = batch_q[j-1];
          j--;
        end
        batch_q[j] = moving;
      end
      if (typed) begin
        due_sorted_q.push_back(want);
      end else begin
        for (int k = 0; k < n; k++) begin
          beat.height  = batch_q[k].height;
          beat.weight  = batch_q[k].weight;
          beat.average = sum_key(batch_q[k]);
          beat.tag     = batch_q[k].tag;
          beat.last    = (k == n - 1);
          beat.dropped = batch_dropped;
          due_sorted_q.push_back(beat);
        end
      end
      batch_q.delete();
      batch_dropped = 1'b0;
    end
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off after the full batch
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_armed && out_ch.valid) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_armed = 1'b0;
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // compare each sorted beat with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_sorted_q.size() == 0) begin
        $error("sorted beat with none due, sorted_tag %h", out_ch.sorted_tag);
        fail_count++;
      end else begin
        head = due_sorted_q.pop_front();
        if (out_ch.sorted_height !== head.height) begin
          $error("sorted_height: expected %h, got %h", head.height, out_ch.sorted_height);
          fail_count++;
        end
        if (out_ch.sorted_weight !== head.weight) begin
          $error("sorted_weight: expected %h, got %h", head.weight, out_ch.sorted_weight);
          fail_count++;
        end
        if (out_ch.record_average !== head.average) begin
          $error("record_average: expected %h, got %h", head.average, out_ch.record_average);
          fail_count++;
        end
        if (out_ch.sorted_tag !== head.tag) begin
          $error("sorted_tag: expected %h, got %h", head.tag, out_ch.sorted_tag);
          fail_count++;
        end
        if (out_ch.batch_end !== head.last) begin
          $error("batch_end: expected %b, got %b", head.last, out_ch.batch_end);
          fail_count++;
        end
        if (out_ch.overflow_seen !== head.dropped) begin
          $error("overflow_seen: expected %b, got %b", head.dropped, out_ch.overflow_seen);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stable_record_merge_sort test failed");
      $finish;
    end
  end

  initial begin
    srms_pkg::rec_t r;
    int             size;
    int             rnd_sent;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.height_value = '0;
    in_ch.weight_value = '0;
    in_ch.record_tag   = '0;
    in_ch.final_record = 1'b0;
    quiet              = 1'b0;
    hold_armed         = 1'b0;
    batch_dropped      = 1'b0;
    rnd_sent           = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      r.height = DIRECTED[i].h;
      r.weight = DIRECTED[i].w;
      r.tag    = DIRECTED[i].tag;
      put_record(r, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // store filled exactly, then the receiver sits on the output for a long stretch
    quiet = 1'b1;
    for (int k = 0; k < MAX_RECORDS; k++) begin
      r.height = 16'($urandom_range(0, 16'hffff));
      r.weight = 16'($urandom_range(0, 16'hffff));
      r.tag    = 16'(k);
      put_record(r, k == MAX_RECORDS - 1, 1'b0, '0);
    end
    hold_armed = 1'b1;
    quiet      = 1'b0;

    // two records past the depth; the final mark lands on a dropped record
    for (int k = 0; k < MAX_RECORDS + 2; k++) begin
      r.height = 16'($urandom_range(0, 7));
      r.weight = 16'($urandom_range(0, 7));
      r.tag    = 16'($urandom_range(0, 16'hffff));
      put_record(r, k == MAX_RECORDS + 1, 1'b0, '0);
    end

    // random batches, mostly small, now and then past the store depth
    while (rnd_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 6);
      else size = $urandom_range(1, 12);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < size; k++) begin
        case ($urandom_range(0, 9))
          5, 6, 7: begin
            // tiny values so that equal keys are common
            r.height = 16'($urandom_range(0, 3));
            r.weight = 16'($urandom_range(0, 3));
          end
          8: begin
            r.height = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            r.weight = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
          end
          9: begin
            r.height = 16'(16'hffff - $urandom_range(0, 2));
            r.weight = 16'(16'hffff - $urandom_range(0, 2));
          end
          default: begin
            r.height = 16'($urandom_range(0, 16'hffff));
            r.weight = 16'($urandom_range(0, 16'hffff));
          end
        endcase
        r.tag = 16'($urandom_range(0, 16'hffff));
        put_record(r, k == size - 1, 1'b0, '0);
      end
      rnd_sent += size;
    end
    in_ch.valid = 1'b0;
    quiet       = 1'b0;

    while (due_sorted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("stable_record_merge_sort test passed");
    end else begin
      $display("stable_record_merge_sort test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
